/* hdl/rnrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnrs_pkg
// shared types and constants of the rms row scaler
// ----------------------------------------------------------------------------
package rnrs_pkg;

  localparam int MAX_ROW = 4096;
  localparam int ADDR_W  = $clog2(MAX_ROW);
  localparam int LEN_W   = 13;

  localparam logic [LEN_W-1:0] ROW_LEN_RESET = 13'd2560;
  localparam logic [7:0]       EPS_Q24       = 8'd168;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_PUSH  = 2'd1;
  localparam logic [1:0] FUNC_DRAIN = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_PUSH,
    OP_DRAIN
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_EPS,
    ST_SQRT,
    ST_RSETUP,
    ST_INV,
    ST_FIN,
    ST_MUL1,
    ST_MUL2,
    ST_OUT
  } bstate_t;

  typedef struct packed {
    op_t                op;
    logic [11:0]        gain_index;
    logic signed [15:0] gain_value;
    logic signed [23:0] element_value;
  } item_t;

  typedef struct packed {
    logic signed [23:0] norm_value;
    logic               row_end;
    logic               status;
  } result_t;

endpackage

/* hdl/rnrs_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnrs_front
// accepts input transactions, decodes func and queues those with a defined func for the back end
// ----------------------------------------------------------------------------
module rnrs_front import rnrs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_func,
  input  logic [11:0]        in_gain_index,
  input  logic signed [15:0] in_gain_value,
  input  logic signed [23:0] in_element_value,
  output logic               q_valid,
  output item_t              q_item,
  input  logic               q_pop
);

  item_t       entry_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        acc, keep;
  item_t       dec;

  assign in_full = (cnt_r == 2'd2);
  assign acc     = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = entry_r[rp_r];

  always_comb begin
    dec.gain_index    = in_gain_index;
    dec.gain_value    = in_gain_value;
    dec.element_value = in_element_value;
    keep              = 1'b1;
    case (in_func)
      FUNC_LOAD:  dec.op = OP_LOAD;
      FUNC_PUSH:  dec.op = OP_PUSH;
      FUNC_DRAIN: dec.op = OP_DRAIN;
      default: begin
        dec.op = OP_LOAD;
        keep   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (acc && keep) begin
      entry_r[wp_r] <= dec;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (acc && keep) wp_r <= ~wp_r;
      if (q_pop)       rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, acc && keep} - {1'b0, q_pop};
    end
  end

endmodule

/* hdl/rnrs_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnrs_back
// sequencer: gain and row storage, square sum, rsqrt units, drain datapath
// ----------------------------------------------------------------------------
module rnrs_back import rnrs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [LEN_W-1:0] row_length,
  input  logic             q_valid,
  input  item_t            q_item,
  output logic             q_pop,
  input  logic             res_space,
  output logic             res_push,
  output result_t          res_data
);

  logic signed [15:0] gain_mem [MAX_ROW];
  logic signed [23:0] row_mem  [MAX_ROW];
  logic [15:0]        gain_rd_r;
  logic [23:0]        row_rd_r;

  bstate_t     state_r, state_nxt;
  logic [59:0] sum_r, sum_nxt;
  logic [12:0] fill_r, fill_nxt;
  logic [23:0] inv_r, inv_nxt;
  logic [12:0] ptr_r, ptr_nxt;
  logic        ready_r, ready_nxt;
  logic [46:0] sq_r, sq_nxt;
  logic [59:0] dq_r, dq_nxt;
  logic [12:0] drem_r, drem_nxt;
  logic [63:0] sv_r, sv_nxt, sres_r, sres_nxt, sbit_r, sbit_nxt;
  logic [35:0] iq_r, iq_nxt;
  logic [32:0] irem_r, irem_nxt;
  logic [31:0] rms_r, rms_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [38:0] p1_r, p1_nxt;
  logic [62:0] p2_r, p2_nxt;
  logic        neg_r, neg_nxt;

  logic        gain_we, row_we;
  logic [12:0] fill_base, eff_len;
  logic [23:0] mag_e, mag_x;
  logic [15:0] mag_g;
  logic [60:0] acc_sum, ms;
  logic [13:0] dtrial;
  logic [63:0] st;
  logic [32:0] itrial;
  logic [31:0] rms0;
  logic [63:0] rnd_full;
  logic [35:0] rnd;
  logic [23:0] nv;
  logic        last;

  always_comb begin
    if (row_length == 13'd0)              eff_len = 13'd1;
    else if (row_length > 13'(MAX_ROW))   eff_len = 13'(MAX_ROW);
    else                                  eff_len = row_length;
  end

  always_ff @(posedge clk) begin
    if (gain_we) gain_mem[q_item.gain_index] <= q_item.gain_value;
    gain_rd_r <= gain_mem[ptr_r[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[fill_base[ADDR_W-1:0]] <= q_item.element_value;
    row_rd_r <= row_mem[ptr_r[ADDR_W-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    sum_nxt = sum_r; fill_nxt = fill_r; inv_nxt = inv_r; ptr_nxt = ptr_r;
    ready_nxt = ready_r; sq_nxt = sq_r; dq_nxt = dq_r; drem_nxt = drem_r;
    sv_nxt = sv_r; sres_nxt = sres_r; sbit_nxt = sbit_r; iq_nxt = iq_r;
    irem_nxt = irem_r; rms_nxt = rms_r; cnt_nxt = cnt_r; p1_nxt = p1_r;
    p2_nxt = p2_r; neg_nxt = neg_r;
    q_pop = 1'b0; res_push = 1'b0; gain_we = 1'b0; row_we = 1'b0;
    res_data = '0;
    fill_base = ready_r ? 13'd0 : fill_r;
    mag_e = q_item.element_value[23] ? (~q_item.element_value + 24'd1)
                                     : q_item.element_value;
    mag_x = row_rd_r[23] ? (~row_rd_r + 24'd1) : row_rd_r;
    mag_g = gain_rd_r[15] ? (~gain_rd_r + 16'd1) : gain_rd_r;
    acc_sum = {1'b0, sum_r} + {14'd0, sq_r};
    ms = {1'b0, dq_r} + {53'd0, EPS_Q24};
    dtrial = {drem_r, dq_r[59]};
    st = sres_r + sbit_r;
    itrial = {irem_r[31:0], iq_r[35]};
    rms0 = (sres_r[31:0] == 32'd0) ? 32'd1 : sres_r[31:0];
    rnd_full = {1'b0, p2_r} + 64'h0000_0000_0800_0000;
    rnd = rnd_full[63:28];
    last = ({1'b0, ptr_r} + 14'd1) >= {1'b0, fill_r};
    if (neg_r) nv = (rnd > 36'h80_0000) ? 24'h80_0000 : (~rnd[23:0] + 24'd1);
    else       nv = (rnd > 36'h7F_FFFF) ? 24'h7F_FFFF : rnd[23:0];

    case (state_r)
      ST_IDLE: begin
        if (q_valid && res_space) begin
          q_pop = 1'b1;
          case (q_item.op)
            OP_LOAD: gain_we = 1'b1;
            OP_PUSH: begin
              if (ready_r) begin
                ready_nxt = 1'b0;
                ptr_nxt   = 13'd0;
                sum_nxt   = '0;
              end
              if (fill_base < 13'(MAX_ROW)) begin
                row_we   = 1'b1;
                fill_nxt = fill_base + 13'd1;
              end else begin
                fill_nxt = fill_base;
              end
              sq_nxt    = 47'(mag_e * mag_e);
              state_nxt = ST_ACC;
            end
            OP_DRAIN: begin
              if (!ready_r) begin
                res_push        = 1'b1;
                res_data.status = 1'b1;
              end else begin
                state_nxt = ST_MUL1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ACC: begin
        sum_nxt = acc_sum[60] ? '1 : acc_sum[59:0];
        if (fill_r >= eff_len) begin
          dq_nxt    = sum_nxt;
          drem_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (dtrial >= {1'b0, fill_r}) begin
          drem_nxt = 13'(dtrial - {1'b0, fill_r});
          dq_nxt   = {dq_r[58:0], 1'b1};
        end else begin
          drem_nxt = dtrial[12:0];
          dq_nxt   = {dq_r[58:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd59) state_nxt = ST_EPS;
      end
      ST_EPS: begin
        sv_nxt    = {ms[47:0], 16'd0};
        sres_nxt  = '0;
        sbit_nxt  = 64'h4000_0000_0000_0000;
        cnt_nxt   = '0;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        if (sv_r >= st) begin
          sv_nxt   = sv_r - st;
          sres_nxt = (sres_r >> 1) + sbit_r;
        end else begin
          sres_nxt = sres_r >> 1;
        end
        sbit_nxt = sbit_r >> 2;
        cnt_nxt  = cnt_r + 6'd1;
        if (cnt_r == 6'd31) state_nxt = ST_RSETUP;
      end
      ST_RSETUP: begin
        rms_nxt   = rms0;
        iq_nxt    = 36'h8_0000_0000 + {5'd0, rms0[31:1]};
        irem_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = ST_INV;
      end
      ST_INV: begin
        if (itrial >= {1'b0, rms_r}) begin
          irem_nxt = itrial - {1'b0, rms_r};
          iq_nxt   = {iq_r[34:0], 1'b1};
        end else begin
          irem_nxt = itrial;
          iq_nxt   = {iq_r[34:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd35) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        inv_nxt   = (|iq_r[35:24]) ? 24'hFF_FFFF : iq_r[23:0];
        ready_nxt = 1'b1;
        ptr_nxt   = 13'd0;
        sum_nxt   = '0;
        state_nxt = ST_IDLE;
      end
      ST_MUL1: begin
        p1_nxt    = 39'(mag_x * mag_g);
        neg_nxt   = row_rd_r[23] ^ gain_rd_r[15];
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        p2_nxt    = 63'(p1_r * inv_r);
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        res_push            = 1'b1;
        res_data.norm_value = nv;
        res_data.row_end    = last;
        if (last) begin
          ready_nxt = 1'b0;
          fill_nxt  = 13'd0;
          ptr_nxt   = 13'd0;
        end else begin
          ptr_nxt = ptr_r + 13'd1;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    sq_r <= sq_nxt; dq_r <= dq_nxt; drem_r <= drem_nxt; sv_r <= sv_nxt;
    sres_r <= sres_nxt; sbit_r <= sbit_nxt; iq_r <= iq_nxt; irem_r <= irem_nxt;
    rms_r <= rms_nxt; cnt_r <= cnt_nxt; p1_r <= p1_nxt; p2_r <= p2_nxt;
    neg_r <= neg_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sum_r   <= '0;
      fill_r  <= '0;
      inv_r   <= '0;
      ptr_r   <= '0;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      fill_r  <= fill_nxt;
      inv_r   <= inv_nxt;
      ptr_r   <= ptr_nxt;
      ready_r <= ready_nxt;
    end
  end

endmodule

/* hdl/rnrs_outq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnrs_outq
// two-entry result queue in front of the output ports
// ----------------------------------------------------------------------------
module rnrs_outq import rnrs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_push,
  input  result_t res_data,
  output logic    res_space,
  output logic    out_empty,
  input  logic    out_pop,
  output result_t head
);

  result_t    entry_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign res_space = (cnt_r != 2'd2);
  assign out_empty = (cnt_r == 2'd0);
  assign pop       = out_pop && !out_empty;
  assign head      = entry_r[rp_r];

  always_ff @(posedge clk) begin
    if (res_push) entry_r[wp_r] <= res_data;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (res_push) wp_r <= ~wp_r;
      if (pop)      rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, res_push} - {1'b0, pop};
    end
  end

endmodule

/* hdl/rms_norm_row_scaler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_norm_row_scaler
// rms normalization of one row with per-dimension gain, Q11.12 fixed point
// ----------------------------------------------------------------------------
// channel  | handshake            | payload
// in_      | in_push / in_full    | func, gain_index, gain_value, element_value
// out_     | out_empty / out_pop  | norm_value, row_end, status
// cfg_     | cfg_valid / cfg_ready| row_length
//
// a push passes the accumulate state; a drain of a ready row passes ST_MUL1,
// ST_MUL2 and ST_OUT. the push that completes a row also runs a 60-step divider
// for the mean, 32-step square root, 36-step reciprocal divider, one step each.
// rst_n clears control state; row and gain memories are not cleared.
// a two-entry input queue and a two-entry result queue decouple both sides.
module rms_norm_row_scaler import rnrs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_func,
  input  logic [11:0]        in_gain_index,
  input  logic signed [15:0] in_gain_value,
  input  logic signed [23:0] in_element_value,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [23:0] out_norm_value,
  output logic               out_row_end,
  output logic               out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LEN_W-1:0]   cfg_data
);

  logic [LEN_W-1:0] row_length_r;
  logic             q_valid, q_pop, res_push, res_space;
  item_t            q_item;
  result_t          res_data, head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= ROW_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      row_length_r <= cfg_data;
    end
  end

  rnrs_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_func, .in_gain_index,
    .in_gain_value, .in_element_value, .q_valid, .q_item, .q_pop
  );

  rnrs_back u_back (
    .clk, .rst_n, .row_length(row_length_r), .q_valid, .q_item, .q_pop,
    .res_space, .res_push, .res_data
  );

  rnrs_outq u_outq (
    .clk, .rst_n, .res_push, .res_data, .res_space, .out_empty, .out_pop, .head
  );

  assign out_norm_value = head.norm_value;
  assign out_row_end    = head.row_end;
  assign out_status     = head.status;

endmodule

/* hdl/rnrs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnrs_checker
// port-level checks of the rms row scaler
// ----------------------------------------------------------------------------
module rnrs_checker import rnrs_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input logic signed [23:0] out_norm_value,
  input logic               out_row_end,
  input logic               out_status
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status) |-> (out_norm_value == 24'sd0))
    else $error("error result carries a value");

  a_err_no_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status) |-> !out_row_end)
    else $error("error result marks row end");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("result withdrawn without pop");

endmodule

bind rms_norm_row_scaler rnrs_checker u_checker (
  .clk, .rst_n, .in_full, .out_empty, .out_pop, .out_norm_value,
  .out_row_end, .out_status
);

/* verif/tb_rms_norm_row_scaler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rms_norm_row_scaler
// self-checking bench: queued driver and monitor around a bit-true predictor
// of the rms row normalizer, with directed corner rows, an oversized row
// length and random row traffic under several idle and stall mixes
// ----------------------------------------------------------------------------
module tb_rms_norm_row_scaler;
  import rnrs_pkg::*;

  typedef struct {
    logic [1:0]         func;
    logic [11:0]        gain_index;
    logic signed [15:0] gain_value;
    logic signed [23:0] element_value;
  } req_t;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 600;
  localparam int GAIN_ENTRIES   = 16;
  localparam int PHASE_ITEMS    = 180;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic [1:0]         in_func = '0;
  logic [11:0]        in_gain_index = '0;
  logic signed [15:0] in_gain_value = '0;
  logic signed [23:0] in_element_value = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic signed [23:0] out_norm_value;
  logic               out_row_end;
  logic               out_status;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LEN_W-1:0]   cfg_data = '0;

  rms_norm_row_scaler DUT (.*);

  always #2 clk = ~clk;

  req_t    pending_q[$];
  result_t norm_q[$];
  int      errors = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;

  // predictor state
  logic [15:0]       gain_tab[MAX_ROW];
  logic [23:0]       row_mem[MAX_ROW];
  longint unsigned   sq_acc = 0;
  int unsigned       filled = 0;
  longint unsigned   inv_rms = 0;
  int unsigned       drain_at = 0;
  bit                row_full = 1'b0;
  int unsigned       len_reg = ROW_LEN_RESET;

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void close_row();
    longint unsigned n = (filled != 0) ? filled : 1;
    longint unsigned ms = sq_acc / n + EPS_Q24;
    longint unsigned rms = floor_sqrt(ms << 16);
    longint unsigned q;
    if (rms == 0) rms = 1;
    q = ((64'd1 << 35) + (rms >> 1)) / rms;
    inv_rms = (q > 64'hFFFFFF) ? 64'hFFFFFF : q;
    sq_acc = 0;
    drain_at = 0;
    row_full = 1'b1;
  endfunction

  function automatic void predict(req_t r);
    longint signed   x, g;
    longint unsigned mag, prod, sq;
    int unsigned     eff;
    bit              neg;
    result_t         res;
    case (r.func)
      FUNC_LOAD: begin
        gain_tab[r.gain_index] = r.gain_value;
      end
      FUNC_PUSH: begin
        x = r.element_value;
        mag = (x < 0) ? -x : x;
        sq = mag * mag;
        if (row_full) begin
          row_full = 1'b0;
          filled = 0;
          drain_at = 0;
          sq_acc = 0;
        end
        if (filled < MAX_ROW) begin
          row_mem[filled] = r.element_value;
          filled++;
        end
        sq_acc = (sq_acc > (64'h0FFF_FFFF_FFFF_FFFF - sq)) ?
                 64'h0FFF_FFFF_FFFF_FFFF : sq_acc + sq;
        eff = (len_reg == 0) ? 1 : ((len_reg > MAX_ROW) ? MAX_ROW : len_reg);
        if (filled >= eff) close_row();
      end
      FUNC_DRAIN: begin
        res = '0;
        if (!row_full || drain_at >= MAX_ROW) begin
          res.status = 1'b1;
        end else begin
          x = $signed(row_mem[drain_at]);
          g = $signed(gain_tab[drain_at]);
          neg = (x < 0) != (g < 0);
          mag = ((x < 0) ? -x : x) * ((g < 0) ? -g : g);
          prod = (mag * inv_rms + (64'd1 << 27)) >> 28;
          if (neg) res.norm_value = (prod > 64'd8388608) ? -24'sd8388608 : -prod;
          else res.norm_value = (prod > 64'd8388607) ? 24'sd8388607 : prod;
          res.row_end = (drain_at + 1 >= filled);
          if (res.row_end) begin
            row_full = 1'b0;
            filled = 0;
            drain_at = 0;
          end else begin
            drain_at++;
          end
        end
        norm_q.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    req_t nxt;
    if (rst_n) begin
      if (in_push && !in_full) begin
        nxt.func = in_func;
        nxt.gain_index = in_gain_index;
        nxt.gain_value = in_gain_value;
        nxt.element_value = in_element_value;
        predict(nxt);
      end
      if (!in_push || !in_full) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_q.pop_front();
          in_func <= nxt.func;
          in_gain_index <= nxt.gain_index;
          in_gain_value <= nxt.gain_value;
          in_element_value <= nxt.element_value;
          in_push <= 1'b1;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t e;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (norm_q.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          e = norm_q.pop_front();
          if (out_norm_value !== e.norm_value) begin
            $error("norm_value expected %0d actual %0d", e.norm_value, out_norm_value);
            errors++;
          end
          if (out_row_end !== e.row_end) begin
            $error("row_end expected %0d actual %0d", e.row_end, out_row_end);
            errors++;
          end
          if (out_status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_status);
            errors++;
          end
        end
      end
      out_pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic add(logic [1:0] f, logic [11:0] gi, logic [15:0] gv, logic [23:0] ev);
    req_t r;
    r.func = f;
    r.gain_index = gi;
    r.gain_value = gv;
    r.element_value = ev;
    pending_q.push_back(r);
  endtask

  function automatic logic [23:0] pick_element();
    case ($urandom_range(7))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2, 3: return 24'($urandom);
      default: return {{8{1'b0}}, 16'($urandom)} - 24'sd32768;
    endcase
  endfunction

  task automatic settle();
    while (pending_q.size() > 0 || in_push || norm_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_row_length(logic [LEN_W-1:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    len_reg = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int sip, int rsp, logic [LEN_W-1:0] len);
    int cnt = 0;
    int n;
    send_idle_pct = sip;
    recv_stall_pct = rsp;
    set_row_length(len);
    while (cnt < PHASE_ITEMS) begin
      if ($urandom_range(99) < 75) begin
        n = (len == 0) ? 1 : len;
        for (int k = 0; k < n; k++) add(FUNC_PUSH, 12'd0, 16'd0, pick_element());
        n += $urandom_range(1) - (($urandom_range(9) == 0) ? 1 : 0);
        for (int k = 0; k < n; k++)
          add(FUNC_DRAIN, 12'($urandom), 16'($urandom), 24'($urandom));
        cnt += 2 * n;
      end else begin
        add(2'($urandom_range(3)), 12'($urandom), 16'($urandom), pick_element());
        cnt++;
      end
    end
    settle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every gain entry that a row can reach gets a value before any drain
    for (int i = 0; i < GAIN_ENTRIES; i++) add(FUNC_LOAD, 12'(i), 16'($urandom), 24'd0);
    settle();

    // directed corners
    set_row_length(3);
    add(FUNC_DRAIN, 0, 0, 0);
    add(FUNC_UNUSED, 12'hFFF, 16'hFFFF, 24'hFFFFFF);
    add(FUNC_LOAD, 0, 16'h8000, 0);
    add(FUNC_LOAD, 1, 16'h7FFF, 0);
    add(FUNC_LOAD, 12'hFFF, 16'h7FFF, 0);
    add(FUNC_PUSH, 0, 0, 24'h800000);
    add(FUNC_PUSH, 0, 0, 24'h7FFFFF);
    add(FUNC_PUSH, 0, 0, 24'h000000);
    for (int k = 0; k < 4; k++) add(FUNC_DRAIN, 0, 0, 0);
    for (int k = 0; k < 3; k++) add(FUNC_PUSH, 0, 0, 0);
    add(FUNC_DRAIN, 0, 0, 0);
    add(FUNC_PUSH, 0, 0, 24'h000001);
    add(FUNC_DRAIN, 0, 0, 0);
    add(FUNC_PUSH, 0, 0, 24'hFFFFFF);
    add(FUNC_PUSH, 0, 0, 24'h001000);
    add(FUNC_PUSH, 0, 0, 24'hFFF000);
    add(FUNC_DRAIN, 0, 0, 0);
    add(FUNC_PUSH, 0, 0, 24'h123456);
    add(FUNC_DRAIN, 0, 0, 0);
    settle();

    // row length above the maximum, then lowered in the middle of a row
    set_row_length(13'h1FFF);
    for (int k = 0; k < 10; k++) add(FUNC_PUSH, 0, 0, pick_element());
    settle();
    set_row_length(3);
    add(FUNC_PUSH, 0, 0, pick_element());
    for (int k = 0; k < 11; k++) add(FUNC_DRAIN, 0, 0, 0);
    settle();

    random_phase(0, 0, 0);
    random_phase(63, 0, LEN_W'($urandom_range(12, 1)));
    random_phase(0, 63, 1);
    random_phase(11, 11, LEN_W'($urandom_range(12, 1)));

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/rnrs_pkg.sv
hdl/rnrs_front.sv
hdl/rnrs_back.sv
hdl/rnrs_outq.sv
hdl/rms_norm_row_scaler.sv
hdl/rnrs_checker.sv
verif/tb_rms_norm_row_scaler.sv
